/* hdl/cidt_pkg.sv */
// Shared types and constants for the command id tracking table.
// Holds field widths, request and status codes, and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package cidt_pkg;

    localparam int ID_BITS          = 16;
    localparam int IN_PAY_BITS      = 48;
    localparam int OUT_PAY_BITS     = 48;
    localparam int SLOT_OUT_BITS    = 6;
    localparam int REQ_BITS         = 2;
    localparam int STATUS_BITS      = 2;

    localparam int DEF_TABLE_DEPTH  = 64;
    localparam int DEF_PAYLOAD_BITS = 48;

    localparam logic [REQ_BITS-1:0] REQ_REGISTER = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR    = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_QUERY    = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_RESERVED = 2'd3;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic find_grp;
        logic find_sel;
        logic read;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/cidt_req_if.sv */
// Request channel interface of the command id tracking table.
// Depends on cidt_pkg for field widths.
`timescale 1ns / 1ps

interface cidt_req_if;
    import cidt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [REQ_BITS-1:0]    req_type;
    logic [ID_BITS-1:0]     cmd_id;
    logic [IN_PAY_BITS-1:0] entry_payload;

    modport source (output valid, output req_type, output cmd_id, output entry_payload,
                    input ready);
    modport sink   (input valid, input req_type, input cmd_id, input entry_payload,
                    output ready);
endinterface

/* hdl/cidt_rsp_if.sv */
// Response channel interface of the command id tracking table.
// Depends on cidt_pkg for field widths.
`timescale 1ns / 1ps

interface cidt_rsp_if;
    import cidt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_BITS-1:0]   status_code;
    logic [SLOT_OUT_BITS-1:0] slot_index;
    logic [ID_BITS-1:0]       out_cmd_id;
    logic [OUT_PAY_BITS-1:0]  out_payload;

    modport source (output valid, output status_code, output slot_index, output out_cmd_id,
                    output out_payload, input ready);
    modport sink   (input valid, input status_code, input slot_index, input out_cmd_id,
                    input out_payload, output ready);
endinterface

/* hdl/cidt_ctrl.sv */
// Sequencing state machine of the command id tracking table.
// Depends on cidt_pkg for the command and status structs and request codes.
`timescale 1ns / 1ps

module cidt_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic [cidt_pkg::REQ_BITS-1:0]  in_req_type,
    output logic                           in_ready,
    input  cidt_pkg::dp_status_t           status,
    output cidt_pkg::dp_cmd_t              cmd
);
    import cidt_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_GRP    = 5'b00010,
        S_SEL    = 5'b00100,
        S_READ   = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                // A word with the reserved opcode is taken and dropped.
                if (in_valid && in_req_type != REQ_RESERVED)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_GRP;
                end
            end
            S_GRP:
            begin
                cmd.find_grp = 1'b1;
                state_next   = S_SEL;
            end
            S_SEL:
            begin
                cmd.find_sel = 1'b1;
                state_next   = S_READ;
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit issued while the output register is occupied");

    a_load_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_GRP))
        else $error("accepted word did not start the search");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !cmd.load)
        else $error("word loaded while a request is in progress");

endmodule

/* hdl/cidt_find.sv */
// Two-level registered priority finder over the slot vector.
// First stage encodes groups of up to 32 slots, second stage picks the group.
// No package dependencies.
`timescale 1ns / 1ps

module cidt_find #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  logic             clk,
    input  logic [DEPTH-1:0] vec,
    input  logic             take_high,
    input  logic             grp_en,
    input  logic             sel_en,
    output logic             hit,
    output logic [IW-1:0]    idx
);
    localparam int GW  = (DEPTH < 32) ? DEPTH : 32;
    localparam int NG  = (DEPTH + GW - 1) / GW;
    localparam int LW  = $clog2(GW);
    localparam int GIW = (NG > 1) ? $clog2(NG) : 1;
    localparam int PW  = NG * GW;
    localparam int SW  = $clog2(PW) + 1;

    logic [PW-1:0] vec_pad;
    logic [NG-1:0] grp_any_next;
    logic [LW-1:0] grp_idx_next [NG];
    logic [NG-1:0] grp_any_reg;
    logic [LW-1:0] grp_idx_reg  [NG];
    logic          hit_next;
    logic [IW-1:0] idx_next;
    logic          hit_reg;
    logic [IW-1:0] idx_reg;

    assign vec_pad = PW'(vec);

    // Per-group encoders; the last set bit in scan order wins.
    always_comb
    begin
        int j;
        for (int g = 0; g < NG; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int b = 0; b < GW; b++)
            begin
                j = take_high ? b : (GW - 1 - b);
                if (vec_pad[g * GW + j])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = LW'(j);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grp_en)
        begin
            grp_any_reg <= grp_any_next;
            for (int g = 0; g < NG; g++)
            begin
                grp_idx_reg[g] <= grp_idx_next[g];
            end
        end
    end

    always_comb
    begin
        int            j;
        logic [GIW-1:0] gsel;
        logic [LW-1:0]  lsel;
        logic [SW-1:0]  sum;
        hit_next = 1'b0;
        gsel     = '0;
        lsel     = '0;
        for (int k = 0; k < NG; k++)
        begin
            j = take_high ? k : (NG - 1 - k);
            if (grp_any_reg[j])
            begin
                hit_next = 1'b1;
                gsel     = GIW'(j);
                lsel     = grp_idx_reg[j];
            end
        end
        sum      = SW'(gsel) * SW'(GW) + SW'(lsel);
        idx_next = sum[IW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (sel_en)
        begin
            hit_reg <= hit_next;
            idx_reg <= idx_next;
        end
    end

    assign hit = hit_reg;
    assign idx = idx_reg;

endmodule

/* hdl/cidt_dp.sv */
// Datapath of the command id tracking table: request registers, slot cells,
// payload memory, finder and the output register. Depends on cidt_pkg and cidt_find.
`timescale 1ns / 1ps

module cidt_dp #(
    parameter int TABLE_DEPTH  = cidt_pkg::DEF_TABLE_DEPTH,
    parameter int PAYLOAD_BITS = cidt_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cidt_pkg::dp_cmd_t                   cmd,
    output cidt_pkg::dp_status_t                status,
    input  logic [cidt_pkg::REQ_BITS-1:0]       in_req_type,
    input  logic [cidt_pkg::ID_BITS-1:0]        in_cmd_id,
    input  logic [cidt_pkg::IN_PAY_BITS-1:0]    in_entry_payload,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cidt_pkg::STATUS_BITS-1:0]    out_status_code,
    output logic [cidt_pkg::SLOT_OUT_BITS-1:0]  out_slot_index,
    output logic [cidt_pkg::ID_BITS-1:0]        out_cmd_id,
    output logic [cidt_pkg::OUT_PAY_BITS-1:0]   out_payload
);
    import cidt_pkg::*;

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int CIW = (PAYLOAD_BITS < IN_PAY_BITS) ? PAYLOAD_BITS : IN_PAY_BITS;
    localparam int COW = (PAYLOAD_BITS < OUT_PAY_BITS) ? PAYLOAD_BITS : OUT_PAY_BITS;
    localparam int XW  = (IW < SLOT_OUT_BITS) ? IW : SLOT_OUT_BITS;

    logic [REQ_BITS-1:0]      op_reg;
    logic [ID_BITS-1:0]       key_reg;
    logic [PAYLOAD_BITS-1:0]  key_pay_reg;
    logic [PAYLOAD_BITS-1:0]  key_pay_next;
    logic [TABLE_DEPTH-1:0]   valid_reg;
    logic [ID_BITS-1:0]       id_cell_reg [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0]  pay_mem     [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0]  rd_pay_reg;
    logic [TABLE_DEPTH-1:0]   search_vec;
    logic                     is_register;
    logic                     hit;
    logic [IW-1:0]            idx;

    logic                     out_valid_reg;
    logic [STATUS_BITS-1:0]   status_reg;
    logic [STATUS_BITS-1:0]   status_next;
    logic [SLOT_OUT_BITS-1:0] slot_reg;
    logic [SLOT_OUT_BITS-1:0] slot_next;
    logic [ID_BITS-1:0]       id_out_reg;
    logic [ID_BITS-1:0]       id_out_next;
    logic [OUT_PAY_BITS-1:0]  pay_out_reg;
    logic [OUT_PAY_BITS-1:0]  pay_out_next;

    always_comb
    begin
        key_pay_next           = '0;
        key_pay_next[CIW-1:0]  = in_entry_payload[CIW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_req_type;
            key_reg     <= in_cmd_id;
            key_pay_reg <= key_pay_next;
        end
    end

    assign is_register = (op_reg == REQ_REGISTER);

    // A register request looks for free slots, a lookup for valid matching ones.
    always_comb
    begin
        for (int s = 0; s < TABLE_DEPTH; s++)
        begin
            search_vec[s] = is_register ? !valid_reg[s]
                                        : (valid_reg[s] && (id_cell_reg[s] == key_reg));
        end
    end

    cidt_find #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_find (
        .clk       (clk),
        .vec       (search_vec),
        .take_high (!is_register),
        .grp_en    (cmd.find_grp),
        .sel_en    (cmd.find_sel),
        .hit       (hit),
        .idx       (idx)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_pay_reg <= pay_mem[idx];
        end
        if (cmd.commit && hit && is_register)
        begin
            pay_mem[idx]     <= key_pay_reg;
            id_cell_reg[idx] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.commit && hit)
        begin
            if (is_register)
            begin
                valid_reg[idx] <= 1'b1;
            end
            else if (op_reg == REQ_CLEAR)
            begin
                valid_reg[idx] <= 1'b0;
            end
        end
    end

    always_comb
    begin
        status_next  = STATUS_OK;
        slot_next    = '0;
        id_out_next  = '0;
        pay_out_next = '0;
        if (!hit)
        begin
            status_next = is_register ? STATUS_FULL : STATUS_NOT_FOUND;
        end
        else
        begin
            slot_next[XW-1:0] = idx[XW-1:0];
            id_out_next       = key_reg;
            if (is_register)
            begin
                pay_out_next[COW-1:0] = key_pay_reg[COW-1:0];
            end
            else
            begin
                pay_out_next[COW-1:0] = rd_pay_reg[COW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            status_reg  <= status_next;
            slot_reg    <= slot_next;
            id_out_reg  <= id_out_next;
            pay_out_reg <= pay_out_next;
        end
    end

    assign status.out_free  = !out_valid_reg || out_ready;
    assign out_valid        = out_valid_reg;
    assign out_status_code  = status_reg;
    assign out_slot_index   = slot_reg;
    assign out_cmd_id       = id_out_reg;
    assign out_payload      = pay_out_reg;

    a_register_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && hit && is_register) |=> valid_reg[$past(idx)])
        else $error("registered slot is not valid after commit");

    a_clear_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && hit && op_reg == REQ_CLEAR) |=> !valid_reg[$past(idx)])
        else $error("cleared slot is still valid after commit");

    a_failed_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STATUS_OK)
            |-> (slot_reg == '0 && id_out_reg == '0 && pay_out_reg == '0))
        else $error("failed result carries nonzero slot data");

endmodule

/* hdl/command_id_tracking_table.sv */
// Top level of the command id tracking table.
// Depends on cidt_pkg, cidt_req_if, cidt_rsp_if, cidt_ctrl and cidt_dp.
//
//   Channel   | Dir | Word contents
//   ----------+-----+-----------------------------------------------------
//   request   | in  | req_type, cmd_id, entry_payload
//   response  | out | status_code, slot_index, out_cmd_id, out_payload
//
// A request word is loaded into the output register after a group encode stage
// and a group select stage of the slot finder, a registered read of the payload
// memory, and a commit that updates the slots and the output register. The next
// word is accepted in the cycle after the commit, so a new word is not taken
// until the last one has committed.
// A word with the reserved opcode is taken with no result.
// Reset clears all slot valid bits and the output valid flag at once.
// A result waiting on the response channel does not block acceptance of the next
// word; the commit of that word waits until the output register is free.
`timescale 1ns / 1ps

module command_id_tracking_table #(
    parameter int TABLE_DEPTH  = cidt_pkg::DEF_TABLE_DEPTH,
    parameter int PAYLOAD_BITS = cidt_pkg::DEF_PAYLOAD_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    cidt_req_if.sink     request,
    cidt_rsp_if.source   response
);
    import cidt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;

    cidt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (request.valid),
        .in_req_type (request.req_type),
        .in_ready    (in_ready),
        .status      (status),
        .cmd         (cmd)
    );

    cidt_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_req_type      (request.req_type),
        .in_cmd_id        (request.cmd_id),
        .in_entry_payload (request.entry_payload),
        .out_valid        (response.valid),
        .out_ready        (response.ready),
        .out_status_code  (response.status_code),
        .out_slot_index   (response.slot_index),
        .out_cmd_id       (response.out_cmd_id),
        .out_payload      (response.out_payload)
    );

    assign request.ready = in_ready;

endmodule

/* dv/cidt_tb_pkg.sv */
// Mirror of the command id tracking table for the testbench: result word type and
// a class that tracks slot contents and checks response words in order.
// Depends on cidt_pkg for field widths, request and status codes.
`timescale 1ns / 1ps

package cidt_tb_pkg;
    import cidt_pkg::*;

    typedef struct packed {
        logic [STATUS_BITS-1:0]   status_code;
        logic [SLOT_OUT_BITS-1:0] slot_index;
        logic [ID_BITS-1:0]       out_cmd_id;
        logic [OUT_PAY_BITS-1:0]  out_payload;
    } result_word_t;

    class slot_table_mirror;
        bit                     slot_live[DEF_TABLE_DEPTH];
        logic [ID_BITS-1:0]     slot_cmd[DEF_TABLE_DEPTH];
        logic [OUT_PAY_BITS-1:0] slot_data[DEF_TABLE_DEPTH];
        result_word_t           due_results[$];
        int                     fail_count;

        function new();
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            fail_count = 0;
        endfunction

        // Updates the mirrored slots for an accepted request word and queues its result.
        function void note_request(logic [REQ_BITS-1:0] op, logic [ID_BITS-1:0] id,
                                   logic [IN_PAY_BITS-1:0] pay);
            result_word_t res;
            int hit;
            res = '0;
            hit = -1;
            if (op == REQ_REGISTER)
            begin
                for (int i = DEF_TABLE_DEPTH - 1; i >= 0; i--)
                begin
                    if (!slot_live[i])
                        hit = i;
                end
                if (hit < 0)
                begin
                    res.status_code = STATUS_FULL;
                end
                else
                begin
                    slot_live[hit]   = 1'b1;
                    slot_cmd[hit]    = id;
                    slot_data[hit]   = pay;
                    res.status_code  = STATUS_OK;
                    res.slot_index   = hit[SLOT_OUT_BITS-1:0];
                    res.out_cmd_id   = id;
                    res.out_payload  = pay;
                end
                due_results.push_back(res);
            end
            else if (op == REQ_CLEAR || op == REQ_QUERY)
            begin
                // The highest matching slot wins when an id is held more than once.
                for (int i = 0; i < DEF_TABLE_DEPTH; i++)
                begin
                    if (slot_live[i] && slot_cmd[i] == id)
                        hit = i;
                end
                if (hit < 0)
                begin
                    res.status_code = STATUS_NOT_FOUND;
                end
                else
                begin
                    res.status_code = STATUS_OK;
                    res.slot_index  = hit[SLOT_OUT_BITS-1:0];
                    res.out_cmd_id  = slot_cmd[hit];
                    res.out_payload = slot_data[hit];
                    if (op == REQ_CLEAR)
                        slot_live[hit] = 1'b0;
                end
                due_results.push_back(res);
            end
        endfunction

        function void check_result(result_word_t got);
            result_word_t want;
            if (due_results.size() == 0)
            begin
                $error("unexpected result word: status_code %0d slot_index %0d out_cmd_id %h",
                       got.status_code, got.slot_index, got.out_cmd_id);
                fail_count++;
                return;
            end
            want = due_results.pop_front();
            if (got.status_code !== want.status_code)
            begin
                $error("status_code: expected %0d, actual %0d", want.status_code,
                       got.status_code);
                fail_count++;
            end
            if (got.slot_index !== want.slot_index)
            begin
                $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
                fail_count++;
            end
            if (got.out_cmd_id !== want.out_cmd_id)
            begin
                $error("out_cmd_id: expected %h, actual %h", want.out_cmd_id, got.out_cmd_id);
                fail_count++;
            end
            if (got.out_payload !== want.out_payload)
            begin
                $error("out_payload: expected %h, actual %h", want.out_payload,
                       got.out_payload);
                fail_count++;
            end
        endfunction

        // An id currently held in some slot, so that lookups find something.
        function logic [ID_BITS-1:0] pick_live_id();
            int held[$];
            for (int i = 0; i < DEF_TABLE_DEPTH; i++)
            begin
                if (slot_live[i])
                    held.push_back(i);
            end
            if (held.size() == 0)
                return ID_BITS'($urandom_range(7));
            return slot_cmd[held[$urandom_range(held.size() - 1)]];
        endfunction
    endclass

endpackage

/* dv/tb_top.sv */
// Testbench top for the command id tracking table: directed and random request words
// under several idling phases, with results checked against a slot table mirror.
// Depends on cidt_pkg, cidt_tb_pkg, the two channel interfaces and the table RTL.
`timescale 1ns / 1ps

module tb_top;
    import cidt_pkg::*;
    import cidt_tb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_left      = 0;
    int   cycle_count    = 0;

    slot_table_mirror table_mirror;

    cidt_req_if req_if();
    cidt_rsp_if rsp_if();

    command_id_tracking_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            table_mirror.check_result({rsp_if.status_code, rsp_if.slot_index,
                                       rsp_if.out_cmd_id, rsp_if.out_payload});
    end

    // Response side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken,
    // with valid still high so the next word can follow without a gap.
    task automatic send_word(input logic [REQ_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                             input logic [IN_PAY_BITS-1:0] pay);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.req_type      <= op;
        req_if.cmd_id        <= id;
        req_if.entry_payload <= pay;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        table_mirror.note_request(op, id, pay);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(negedge clk);
        while (table_mirror.due_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_directed();
        send_word(REQ_QUERY, 16'h0000, '0);
        send_word(REQ_CLEAR, 16'hFFFF, '1);
        send_word(REQ_REGISTER, 16'h0000, '0);
        send_word(REQ_REGISTER, 16'hFFFF, '1);
        send_word(REQ_REGISTER, 16'h1234, 48'hA5A5_5A5A_0F0F);
        // Same id again: lookups must land on the higher slot.
        send_word(REQ_REGISTER, 16'h1234, 48'h5A5A_A5A5_F0F0);
        send_word(REQ_QUERY, 16'h1234, '1);
        send_word(REQ_RESERVED, 16'h1234, '0);
        send_word(REQ_CLEAR, 16'h1234, '0);
        send_word(REQ_QUERY, 16'h1234, '0);
        send_word(REQ_CLEAR, 16'h0000, '1);
        // The freed slot zero is the lowest free one again.
        send_word(REQ_REGISTER, 16'h0007, 48'h8000_0000_0001);
        send_word(REQ_QUERY, 16'hFFFF, '0);
        send_word(REQ_CLEAR, 16'hFFFF, '0);
        send_word(REQ_CLEAR, 16'hFFFF, '0);
        send_word(REQ_RESERVED, 16'hFFFF, '1);
        send_word(REQ_QUERY, 16'h0007, '0);
        send_word(REQ_CLEAR, 16'h1234, '0);
        send_word(REQ_CLEAR, 16'h0007, '0);
        send_word(REQ_QUERY, 16'h0007, '0);
    endtask

    task automatic send_random(input bit fill_bias, output bit counted);
        int roll;
        logic [REQ_BITS-1:0]    op;
        logic [ID_BITS-1:0]     id;
        logic [IN_PAY_BITS-1:0] pay;
        roll = $urandom_range(99);
        if (roll < 4)
            op = REQ_RESERVED;
        else if (roll < (fill_bias ? 80 : 14))
            op = REQ_REGISTER;
        else if (roll < (fill_bias ? 90 : 84))
            op = REQ_CLEAR;
        else
            op = REQ_QUERY;
        case ($urandom_range(3))
            0:       id = ID_BITS'($urandom_range(7));
            1:       id = ID_BITS'($urandom);
            default: id = table_mirror.pick_live_id();
        endcase
        case ($urandom_range(9))
            0:       pay = '0;
            1:       pay = '1;
            default: pay = {16'($urandom), $urandom};
        endcase
        send_word(op, id, pay);
        counted = (op != REQ_RESERVED);
    endtask

    // Alternates stretches that fill the table past full with stretches that drain it.
    task automatic run_phase(input int send_idle, input int recv_stall, input int words);
        int done;
        bit counted;
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        done = 0;
        while (done < words)
        begin
            send_random(((done / 110) % 2) == 0, counted);
            if (counted)
                done++;
        end
        wait_drained();
    endtask

    initial
    begin
        table_mirror         = new();
        rst_n                = 1'b0;
        req_if.valid         = 1'b0;
        req_if.req_type      = REQ_REGISTER;
        req_if.cmd_id        = '0;
        req_if.entry_payload = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        run_directed();
        wait_drained();

        // Response side holds off while words keep coming, so the input backs up.
        hold_left = 400;
        run_phase(0, 0, 410);
        run_phase(87, 0, 410);
        run_phase(0, 87, 410);
        run_phase(26, 26, 410);

        repeat (20) @(negedge clk);
        if (table_mirror.fail_count == 0 && table_mirror.due_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
